### design/bnfa_pkg.sv
// bnfa_pkg: shared types and constants of the bitmap next-fit allocator
// request and response payloads, status and request codes, pool bookkeeping structs
// no dependencies
`default_nettype none

package bnfa_pkg;

  localparam int NUM_W    = 13;  // entry numbers, free counters, inode pointer
  localparam int LASTB_W  = 12;  // block pointer
  localparam int IDX_W    = 17;  // bit index over the largest map, plus one
  localparam int START_W  = 10;  // start byte taken from a 13-bit pointer
  localparam int BCNT_W   = 14;  // byte counts up to the largest map size
  localparam int COUNT_MAX = 8191;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic POOL_INODE = 1'b0;
  localparam logic POOL_BLOCK = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_NOBIT   = 2'd2;
  localparam logic [1:0] ST_INVALID = 2'd3;

  typedef struct packed {
    logic             req_type;
    logic             pool;
    logic [NUM_W-1:0] entry_number;
  } req_t;

  typedef struct packed {
    logic [NUM_W-1:0] granted_number;
    logic [1:0]       status;
  } resp_t;

  // bookkeeping update from the sequencer to the pool registers
  typedef struct packed {
    logic             dec;      // allocation done at bit_idx
    logic             inc;      // free done, saturating count up
    logic             pool;
    logic [IDX_W-1:0] bit_idx;
  } pool_upd_t;

  typedef struct packed {
    logic               count_zero;
    logic [START_W-1:0] start_byte;
  } pool_info_t;

endpackage

`default_nettype wire

### design/bnfa_ram.sv
// bnfa_ram: generic single-port synchronous RAM with registered read data
// no reset on contents; depends on nothing
`default_nettype none

module bnfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                                         clk_i,
  input  wire logic                                         we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]                             wdata_i,
  output      logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### design/bnfa_pool.sv
// bnfa_pool: free counters and last-allocated pointers of the inode and block pools
// depends on bnfa_pkg
`default_nettype none

module bnfa_pool #(
  parameter int MAP_BYTES = 512
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   pool_i,
  input  wire bnfa_pkg::pool_upd_t    upd_i,
  output      bnfa_pkg::pool_info_t   info_o
);

  import bnfa_pkg::*;

  localparam int TOTAL = MAP_BYTES * 8;
  localparam int CAP   = (TOTAL > COUNT_MAX) ? COUNT_MAX : TOTAL;
  localparam logic [NUM_W-1:0] CAP_V = NUM_W'(CAP);

  logic [NUM_W-1:0]   inode_cnt_q, inode_cnt_d;
  logic [NUM_W-1:0]   block_cnt_q, block_cnt_d;
  logic [NUM_W-1:0]   last_inode_q, last_inode_d;
  logic [LASTB_W-1:0] last_block_q, last_block_d;
  logic [IDX_W-1:0]   idx_inc;
  logic [NUM_W-1:0]   inode_prev;

  assign idx_inc    = upd_i.bit_idx + IDX_W'(1);
  assign inode_prev = last_inode_q - NUM_W'(1);

  always_comb begin
    inode_cnt_d  = inode_cnt_q;
    block_cnt_d  = block_cnt_q;
    last_inode_d = last_inode_q;
    last_block_d = last_block_q;
    if (upd_i.dec) begin
      if (upd_i.pool == POOL_BLOCK) begin
        block_cnt_d  = block_cnt_q - NUM_W'(1);
        last_block_d = upd_i.bit_idx[LASTB_W-1:0];
      end else begin
        inode_cnt_d  = inode_cnt_q - NUM_W'(1);
        last_inode_d = idx_inc[NUM_W-1:0];
      end
    end else if (upd_i.inc) begin
      if (upd_i.pool == POOL_BLOCK) begin
        if (block_cnt_q < CAP_V) block_cnt_d = block_cnt_q + NUM_W'(1);
      end else begin
        if (inode_cnt_q < CAP_V) inode_cnt_d = inode_cnt_q + NUM_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inode_cnt_q  <= CAP_V;
      block_cnt_q  <= CAP_V;
      last_inode_q <= '0;
      last_block_q <= '0;
    end else begin
      inode_cnt_q  <= inode_cnt_d;
      block_cnt_q  <= block_cnt_d;
      last_inode_q <= last_inode_d;
      last_block_q <= last_block_d;
    end
  end

  // inode pointers are 1-based, zero means start at byte 0
  always_comb begin
    if (pool_i == POOL_BLOCK) begin
      info_o.count_zero = (block_cnt_q == '0);
      info_o.start_byte = START_W'(last_block_q[LASTB_W-1:3]);
    end else begin
      info_o.count_zero = (inode_cnt_q == '0);
      info_o.start_byte = (last_inode_q == '0) ? '0 : inode_prev[NUM_W-1:3];
    end
  end

  a_inode_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inode_cnt_q <= CAP_V)
    else $error("inode free count above capacity");

  a_block_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    block_cnt_q <= CAP_V)
    else $error("block free count above capacity");

endmodule

`default_nettype wire

### design/bitmap_next_fit_allocator.sv
// bitmap_next_fit_allocator: top level, request sequencer, bitmap RAMs and result register
// depends on bnfa_pkg, bnfa_ram, bnfa_pool
//
// Usage: one request enters on the in channel (valid/stall); exactly one response
// leaves on the out channel. An allocate reads the pool's bitmap one byte per cycle,
// starting at the byte holding the last-allocated entry and stopping at the map end;
// the first clear bit (MSB first) is set and its number returned. A free clears one
// bit with a single read-modify-write.
// One request is in work at a time; the single-port bitmap RAM read per cycle sets
// the scan speed.
// Reset: both bitmaps are cleared by a pass over all MAP_BYTES bytes; in_stall_o is high
// during that pass and while a request is in work.
// A stalled response waits in the output register; the next request may already
// be taken and worked on, and its response waits until the register frees up.
`default_nettype none

module bitmap_next_fit_allocator #(
  parameter int MAP_BYTES = 512
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output      logic            in_stall_o,
  input  wire bnfa_pkg::req_t  in_data_i,
  output      logic            out_valid_o,
  input  wire logic            out_stall_i,
  output      bnfa_pkg::resp_t out_data_o
);

  import bnfa_pkg::*;

  localparam int ADDR_W = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int TOTAL  = MAP_BYTES * 8;
  localparam logic [IDX_W-1:0]  TOTAL_V    = IDX_W'(TOTAL);
  localparam logic [BCNT_W-1:0] MAP_V      = BCNT_W'(MAP_BYTES);
  localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(MAP_BYTES - 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_SCAN, S_FREE, S_RESP
  } state_e;

  state_e            state_q, state_d;
  req_t              req_q, req_d;
  resp_t             res_q, res_d;
  resp_t             out_q, out_d;
  logic              out_valid_q, out_valid_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [2:0]        pos_q, pos_d;

  logic              ram_we_inode, ram_we_block;
  logic [ADDR_W-1:0] ram_addr;
  logic [7:0]        ram_wdata;
  logic [7:0]        rd_inode, rd_block, rd_byte;

  pool_upd_t         upd;
  pool_info_t        info;

  logic [BCNT_W-1:0] start_ext;
  logic [IDX_W-1:0]  num_ext, free_idx, scan_idx, scan_idx_inc;
  logic              free_ok;
  logic              zero_found;
  logic [2:0]        zero_pos;
  logic              out_free;

  bnfa_ram #(.WIDTH(8), .DEPTH(MAP_BYTES)) u_inode_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we_inode),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(rd_inode)
  );

  bnfa_ram #(.WIDTH(8), .DEPTH(MAP_BYTES)) u_block_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we_block),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(rd_block)
  );

  bnfa_pool #(.MAP_BYTES(MAP_BYTES)) u_pool (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .pool_i(req_q.pool),
    .upd_i (upd),
    .info_o(info)
  );

  assign rd_byte   = (req_q.pool == POOL_BLOCK) ? rd_block : rd_inode;
  assign start_ext = BCNT_W'(info.start_byte);
  assign num_ext   = IDX_W'(req_q.entry_number);
  assign free_idx  = (req_q.pool == POOL_BLOCK) ? num_ext : num_ext - IDX_W'(1);
  assign free_ok   = (req_q.pool == POOL_BLOCK) ? (num_ext < TOTAL_V) :
                     ((req_q.entry_number != '0) && (num_ext <= TOTAL_V));
  assign scan_idx     = IDX_W'({addr_q, zero_pos});
  assign scan_idx_inc = scan_idx + IDX_W'(1);
  assign out_free     = !out_valid_q || !out_stall_i;

  // first clear bit, MSB first
  always_comb begin
    zero_found = 1'b0;
    zero_pos   = '0;
    for (int i = 0; i < 8; i++) begin
      if (!zero_found && !rd_byte[7-i]) begin
        zero_found = 1'b1;
        zero_pos   = 3'(i);
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    res_d        = res_q;
    addr_d       = addr_q;
    pos_d        = pos_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && out_stall_i;
    ram_we_inode = 1'b0;
    ram_we_block = 1'b0;
    ram_addr     = addr_q;
    ram_wdata    = '0;
    upd          = '0;
    upd.pool     = req_q.pool;
    upd.bit_idx  = scan_idx;

    case (state_q)
      S_CLEAR: begin
        ram_we_inode = 1'b1;
        ram_we_block = 1'b1;
        addr_d       = addr_q + ADDR_W'(1);
        if (addr_q == LAST_ADDR) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_data_i;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        res_d = '{granted_number: '0, status: ST_OK};
        if (req_q.req_type == REQ_ALLOC) begin
          if (info.count_zero) begin
            res_d.status = ST_EMPTY;
            state_d      = S_RESP;
          end else if (start_ext >= MAP_V) begin
            res_d.status = ST_NOBIT;
            state_d      = S_RESP;
          end else begin
            ram_addr = start_ext[ADDR_W-1:0];
            addr_d   = start_ext[ADDR_W-1:0];
            state_d  = S_SCAN;
          end
        end else begin
          if (!free_ok) begin
            res_d.status = ST_INVALID;
            state_d      = S_RESP;
          end else begin
            ram_addr = free_idx[ADDR_W+2:3];
            addr_d   = free_idx[ADDR_W+2:3];
            pos_d    = free_idx[2:0];
            state_d  = S_FREE;
          end
        end
      end
      S_SCAN: begin
        if (zero_found) begin
          ram_wdata = rd_byte | (8'h80 >> zero_pos);
          if (req_q.pool == POOL_BLOCK) begin
            ram_we_block         = 1'b1;
            res_d.granted_number = scan_idx[NUM_W-1:0];
          end else begin
            ram_we_inode         = 1'b1;
            res_d.granted_number = scan_idx_inc[NUM_W-1:0];
          end
          upd.dec      = 1'b1;
          res_d.status = ST_OK;
          state_d      = S_RESP;
        end else if (addr_q == LAST_ADDR) begin
          res_d.status = ST_NOBIT;
          state_d      = S_RESP;
        end else begin
          // full byte, read the next one
          ram_addr = addr_q + ADDR_W'(1);
          addr_d   = addr_q + ADDR_W'(1);
        end
      end
      S_FREE: begin
        ram_wdata = rd_byte & ~(8'h80 >> pos_q);
        if (req_q.pool == POOL_BLOCK) begin
          ram_we_block = 1'b1;
        end else begin
          ram_we_inode = 1'b1;
        end
        upd.inc = 1'b1;
        state_d = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      addr_q      <= '0;
      out_valid_q <= 1'b0;
      req_q       <= '0;
      res_q       <= '0;
      out_q       <= '0;
      pos_q       <= '0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      out_valid_q <= out_valid_d;
      req_q       <= req_d;
      res_q       <= res_d;
      out_q       <= out_d;
      pos_q       <= pos_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_scan_sets_one_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && (ram_we_inode || ram_we_block))
      |-> $countones(ram_wdata) == $countones(rd_byte) + 1)
    else $error("scan write does not set exactly one new bit");

  a_scan_in_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (addr_q <= LAST_ADDR))
    else $error("scan address beyond map end");

  a_resp_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP && out_free) |=> (out_valid_o && out_data_o == $past(res_q)))
    else $error("response not moved into output register");

  a_accept_to_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_CHECK))
    else $error("input transfer did not start a request");

endmodule

`default_nettype wire

### dv/tb.sv
// tb: self-checking bench for bitmap_next_fit_allocator, both pools, one response per request
// holds its own allocator model, a queue-fed driver, a response monitor and random stalls
// depends on bnfa_pkg and bitmap_next_fit_allocator
module tb;
  import bnfa_pkg::*;

  localparam int MAP_BYTES = 512;
  localparam int ENTRIES   = MAP_BYTES * 8;
  localparam int FREE_CAP  = (ENTRIES > COUNT_MAX) ? COUNT_MAX : ENTRIES;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  req_t  in_data = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  resp_t out_data;

  // allocator model state
  logic [7:0]         inode_bits [MAP_BYTES];
  logic [7:0]         block_bits [MAP_BYTES];
  logic [NUM_W-1:0]   inode_free = NUM_W'(FREE_CAP);
  logic [NUM_W-1:0]   block_free = NUM_W'(FREE_CAP);
  logic [NUM_W-1:0]   inode_last = '0;
  logic [LASTB_W-1:0] block_last = '0;

  req_t  req_queue[$];
  resp_t resp_due[$];
  int    n_issued = 0;
  int    n_accepted = 0;
  int    n_errors = 0;

  bitmap_next_fit_allocator #(.MAP_BYTES(MAP_BYTES)) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < MAP_BYTES; i++) begin
      inode_bits[i] = '0;
      block_bits[i] = '0;
    end
  end

  function automatic int inode_start_byte();
    return (inode_last == '0) ? 0 : (int'(inode_last) - 1) / 8;
  endfunction

  // applies one request to the model and returns the response it must produce
  function automatic resp_t apply_request(req_t r);
    resp_t            res;
    logic [7:0]       cur;
    logic [NUM_W-1:0] cnt;
    int               start;
    int               idx;
    int               byte_i;
    int               pos;
    int               num;
    bit               found;
    bit               ok;
    res = '0;
    res.status = ST_OK;
    found = 1'b0;
    idx = 0;
    cnt = (r.pool == POOL_BLOCK) ? block_free : inode_free;
    if (r.req_type == REQ_ALLOC) begin
      start = (r.pool == POOL_BLOCK) ? int'(block_last) / 8 : inode_start_byte();
      if (cnt == '0) begin
        res.status = ST_EMPTY;
      end else begin
        for (byte_i = start; byte_i < MAP_BYTES && !found; byte_i++) begin
          cur = (r.pool == POOL_BLOCK) ? block_bits[byte_i] : inode_bits[byte_i];
          for (pos = 0; pos < 8 && !found; pos++) begin
            if (!cur[7-pos]) begin
              found = 1'b1;
              idx = byte_i * 8 + pos;
              if (r.pool == POOL_BLOCK) block_bits[byte_i][7-pos] = 1'b1;
              else inode_bits[byte_i][7-pos] = 1'b1;
            end
          end
        end
        if (!found) begin
          res.status = ST_NOBIT;
        end else begin
          cnt = cnt - NUM_W'(1);
          if (r.pool == POOL_BLOCK) begin
            block_last = LASTB_W'(idx);
            res.granted_number = NUM_W'(idx);
          end else begin
            inode_last = NUM_W'(idx + 1);
            res.granted_number = inode_last;
          end
        end
      end
    end else begin
      num = int'(r.entry_number);
      if (r.pool == POOL_BLOCK) begin
        ok = (num < ENTRIES);
        idx = num;
      end else begin
        ok = (num >= 1) && (num <= ENTRIES);
        idx = num - 1;
      end
      if (!ok) begin
        res.status = ST_INVALID;
      end else begin
        if (r.pool == POOL_BLOCK) block_bits[idx / 8][7 - idx % 8] = 1'b0;
        else inode_bits[idx / 8][7 - idx % 8] = 1'b0;
        if (int'(cnt) < FREE_CAP) cnt = cnt + NUM_W'(1);
      end
    end
    if (r.pool == POOL_BLOCK) block_free = cnt;
    else inode_free = cnt;
    return res;
  endfunction

  // idle percentage for the sender or the receiver in the current phase
  function automatic int idle_pct(bit receiver);
    int mode;
    mode = (n_accepted / 96) % 4;
    if (mode == 3) return 17;
    if (mode == 1 && !receiver) return 52;
    if (mode == 2 && receiver) return 52;
    return 0;
  endfunction

  // valid inode frees stay inside the scan start byte so the free count never drifts
  // from the map; block requests get no such restriction
  function automatic req_t pick_request();
    req_t r;
    int   roll;
    int   start;
    int   n_set;
    int   k;
    roll = $urandom_range(99);
    r.req_type = REQ_ALLOC;
    r.pool = 1'($urandom_range(1));
    r.entry_number = NUM_W'($urandom);
    if (roll >= 45 && roll < 80) begin
      r.req_type = REQ_FREE;
      if (r.pool == POOL_BLOCK) begin
        r.entry_number = NUM_W'($urandom_range(int'(block_last)));
      end else begin
        start = inode_start_byte();
        n_set = 0;
        for (int p = 0; p < 8; p++) if (inode_bits[start][7-p]) n_set++;
        if (n_set == 0) begin
          r.req_type = REQ_ALLOC;
        end else begin
          k = $urandom_range(n_set - 1);
          for (int p = 0; p < 8; p++) begin
            if (inode_bits[start][7-p]) begin
              if (k == 0) r.entry_number = NUM_W'(start * 8 + p + 1);
              k--;
            end
          end
        end
      end
    end else if (roll >= 80) begin
      r.req_type = REQ_FREE;
      if (r.pool == POOL_INODE)
        r.entry_number = ($urandom_range(3) == 0) ? '0 : NUM_W'($urandom_range(8191, ENTRIES + 1));
    end
    return r;
  endfunction

  // driver: a transfer updates the model, then the next item is loaded or valid drops
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        resp_due.push_back(apply_request(in_data));
        n_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (req_queue.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
          in_data <= req_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compares each response transfer with the oldest expectation
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin : mon
      resp_t want;
      if (out_valid && !out_stall) begin
        if (resp_due.size() == 0) begin
          $error("unexpected response: granted_number %0d status %0d",
                 out_data.granted_number, out_data.status);
          n_errors++;
        end else begin
          want = resp_due.pop_front();
          if (out_data.granted_number !== want.granted_number) begin
            $error("granted_number: expected %0d, actual %0d",
                   want.granted_number, out_data.granted_number);
            n_errors++;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_data.status);
            n_errors++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < idle_pct(1'b1));
    end
  end

  task automatic send(logic kind, logic which, int num);
    req_t r;
    r.req_type = kind;
    r.pool = which;
    r.entry_number = NUM_W'(num);
    req_queue.push_back(r);
    n_issued++;
  endtask

  task automatic wait_accepted();
    while (n_accepted != n_issued) @(negedge clk);
  endtask

  task automatic drain();
    while (n_accepted != n_issued || resp_due.size() != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    int n;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // free at full count saturates, allocate ignores the number, then reuse
    send(REQ_FREE, POOL_INODE, 1);
    send(REQ_FREE, POOL_INODE, ENTRIES);
    send(REQ_ALLOC, POOL_INODE, 8191);
    send(REQ_ALLOC, POOL_INODE, 0);
    send(REQ_FREE, POOL_INODE, 2);
    send(REQ_ALLOC, POOL_INODE, ENTRIES);
    // out of range frees on both pools
    send(REQ_FREE, POOL_INODE, 0);
    send(REQ_FREE, POOL_INODE, ENTRIES + 1);
    send(REQ_FREE, POOL_INODE, 8191);
    send(REQ_FREE, POOL_BLOCK, ENTRIES);
    send(REQ_FREE, POOL_BLOCK, 8191);
    // block pool: zero-based numbers, double frees bump the counter up to the cap
    send(REQ_ALLOC, POOL_BLOCK, 0);
    send(REQ_ALLOC, POOL_BLOCK, ENTRIES - 1);
    send(REQ_ALLOC, POOL_BLOCK, 0);
    send(REQ_FREE, POOL_BLOCK, 0);
    send(REQ_FREE, POOL_BLOCK, 0);
    send(REQ_FREE, POOL_BLOCK, ENTRIES - 1);
    send(REQ_FREE, POOL_BLOCK, ENTRIES - 1);
    send(REQ_ALLOC, POOL_BLOCK, 5461);
    drain();

    // each pick looks at the model after the previous transfer
    repeat (1000) begin
      req_queue.push_back(pick_request());
      n_issued++;
      wait_accepted();
    end
    drain();

    // exhaust the inode pool, then hit the empty and no-bit-left cases
    n = int'(inode_free);
    repeat (n + 2) send(REQ_ALLOC, POOL_INODE, $urandom_range(8191));
    send(REQ_FREE, POOL_INODE, ENTRIES);
    send(REQ_ALLOC, POOL_INODE, 0);
    send(REQ_ALLOC, POOL_INODE, 0);
    send(REQ_FREE, POOL_INODE, 3);
    send(REQ_ALLOC, POOL_INODE, 0);
    send(REQ_ALLOC, POOL_BLOCK, 0);
    drain();

    repeat (MAP_BYTES + 16) @(posedge clk);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #150_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
